@@ rtl/tone_burst_pwm_generator_unit_assert.svh @@
// assertion macros of the checker file of the tone burst generator
// depends on nothing; included by bare file name
`ifndef TONE_BURST_PWM_GENERATOR_UNIT_ASSERT_SVH
`define TONE_BURST_PWM_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define TBPG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tbpg assertion failed");

// next-cycle implication, masked while reset is high
`define TBPG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tbpg assertion failed");

// next-cycle implication that also covers the reset cycles
`define TBPG_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tbpg assertion failed");

`endif

@@ rtl/tbpg_pkg.sv @@
// shared constants, types and helpers of the tone burst pwm generator
// depends on nothing; imported by every design module of the block, used by the checker
`default_nettype none

package tbpg_pkg;

   localparam int MEMORY_DEPTH = 16384;
   localparam int PHASE_BITS   = 20;

   localparam int ADDR_W  = 14;
   localparam int LEN_W   = 15;
   localparam int LEVEL_W = 15;
   localparam int STEP_W  = 20;

   // fade product and serial divider sizes
   localparam int DIV_STEPS = LEVEL_W;
   localparam int PROD_W    = LEN_W + LEVEL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // start + index + 1 must not wrap, and must hold the memory depth itself
   localparam int ADDR_SUM_W = ($clog2(MEMORY_DEPTH) + 1 > LEN_W + 2) ?
                               $clog2(MEMORY_DEPTH) + 1 : LEN_W + 2;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = STEP_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_ADDRESS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BURST_LENGTH    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_STEP      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_CHANGE     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_IN_LENGTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FADE_OUT_LENGTH = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_LEVEL      = 3'd6;

   typedef struct packed {
      logic load;     // restart: phase to zero, step from phase_step
      logic advance;  // add step to phase, chirp on wrap
   } phase_ctrl_type;

   typedef struct packed {
      logic                start;
      logic [PROD_W-1:0]   numerator;
      logic [LEN_W-1:0]    divisor;
   } div_req_type;

   // Q0.20 step aligned to the phase width, truncating when the phase is narrower
   function automatic logic [PHASE_BITS-1:0] align_step(input logic [STEP_W-1:0] s);
      logic [STEP_W+PHASE_BITS-1:0] wide;
      wide = {s, {PHASE_BITS{1'b0}}};
      return wide[STEP_W+PHASE_BITS-1:STEP_W];
   endfunction

endpackage

`default_nettype wire

@@ rtl/tbpg_serial_div.sv @@
// bit-serial restoring divider for the fade duty, one quotient bit a cycle
// depends on tbpg_pkg
`default_nettype none

module tbpg_serial_div (
   input  logic                           clock,
   input  logic                           reset,
   input  tbpg_pkg::div_req_type          div_req,
   output logic                           div_busy,
   output logic [tbpg_pkg::LEVEL_W-1:0]   div_quotient
);
   import tbpg_pkg::*;

   logic                  busy_ff, busy_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [PROD_W-1:0]     work_ff, work_in;
   logic [LEN_W-1:0]      divisor_ff, divisor_in;
   logic [LEN_W:0]        trial;
   logic [LEN_W+1:0]      diff;
   logic                  qbit;
   logic [LEN_W-1:0]      rem_next;

   // upper part holds the partial remainder, lower part shifts numerator out, quotient in
   always_comb begin
      trial    = {work_ff[PROD_W-1:DIV_STEPS], work_ff[DIV_STEPS-1]};
      diff     = {1'b0, trial} - {2'b00, divisor_ff};
      qbit     = ~diff[LEN_W+1];
      rem_next = qbit ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
   end

   always_comb begin
      busy_in    = busy_ff;
      count_in   = count_ff;
      work_in    = work_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         work_in    = div_req.numerator;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         work_in  = {rem_next, work_ff[DIV_STEPS-2:0], qbit};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff    <= work_in;
      divisor_ff <= divisor_in;
   end

   assign div_busy     = busy_ff;
   assign div_quotient = work_ff[DIV_STEPS-1:0];

endmodule

`default_nettype wire

@@ rtl/tbpg_phase.sv @@
// phase accumulator with chirped step, saturated to the step range
// depends on tbpg_pkg
`default_nettype none

module tbpg_phase (
   input  logic                                clock,
   input  logic                                reset,
   input  tbpg_pkg::phase_ctrl_type            phase_ctrl,
   input  logic [tbpg_pkg::STEP_W-1:0]         phase_step,
   input  logic signed [tbpg_pkg::STEP_W-1:0]  step_change,
   output logic                                phase_high
);
   import tbpg_pkg::*;

   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [PHASE_BITS:0]   phase_sum;
   logic [STEP_W+1:0]     chirp_sum;
   logic [STEP_W-1:0]     chirp_sat;

   always_comb begin
      phase_sum = {1'b0, phase_ff} + {1'b0, align_step(step_ff)};
      chirp_sum = {2'b00, step_ff} + {{2{step_change[STEP_W-1]}}, step_change};
      if (chirp_sum[STEP_W+1]) begin
         chirp_sat = '0;
      end else if (chirp_sum[STEP_W]) begin
         chirp_sat = '1;
      end else begin
         chirp_sat = chirp_sum[STEP_W-1:0];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      if (phase_ctrl.load) begin
         phase_in = '0;
         step_in  = phase_step;
      end else if (phase_ctrl.advance) begin
         phase_in = phase_sum[PHASE_BITS-1:0];
         if (phase_sum[PHASE_BITS]) begin
            step_in = chirp_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         step_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
      end
   end

   assign phase_high = phase_ff[PHASE_BITS-1];

endmodule

`default_nettype wire

@@ rtl/tone_burst_pwm_generator_unit.sv @@
// top level of the tone burst pwm generator: registers, sequencer, output stage
// depends on tbpg_pkg, tbpg_phase and tbpg_serial_div
`default_nettype none

// Each transfer on the req_ channel is one tick and gives at most one duty
// sample on the rsp_ channel. A tick with req_restart set starts the burst
// afresh (index and phase to zero, step loaded from phase_step) and already
// gives sample 0 if the burst has one. The duty is zero in the upper half of
// each tone cycle and peak_level otherwise, scaled linearly during the fade-in
// and fade-out windows with floor division. rsp_last marks the final sample of
// the burst or of the sample memory; after it no sample comes until the next
// restart. A tick goes through the idle, evaluation and finish states, and
// its result enters the output register from the finish state once that
// register is empty or its sample is taken. A sample in a fade window and in
// the lower half of the tone cycle also passes through the divide state, where
// the bit-serial divider makes one quotient bit per cycle. A tick that gives
// no sample leaves the block idle or goes from evaluation back to idle. The
// next tick is taken while a finished sample still waits in the output
// register. Register writes are taken at any time (csr_ready is always high)
// and must only happen while no tick is in progress; all but phase_step act
// from the next tick, phase_step only on restart.
module tone_burst_pwm_generator_unit (
   input  logic                                clock,
   input  logic                                reset,
   // tick channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_restart,
   // sample channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tbpg_pkg::ADDR_W-1:0]         rsp_sample_address,
   output logic [tbpg_pkg::LEVEL_W-1:0]        rsp_duty,
   output logic                                rsp_last,
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbpg_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tbpg_pkg::CSR_DATA_W-1:0]     csr_data
);
   import tbpg_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_EVAL   = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   // configuration registers
   logic [ADDR_W-1:0]        start_address_ff;
   logic [LEN_W-1:0]         burst_length_ff;
   logic [STEP_W-1:0]        phase_step_ff;
   logic signed [STEP_W-1:0] step_change_ff;
   logic [LEN_W-1:0]         fade_in_length_ff;
   logic [LEN_W-1:0]         fade_out_length_ff;
   logic [LEVEL_W-1:0]       peak_level_ff;
   logic                     csr_write;

   // burst state and sequencer
   state_type                state_ff, state_in;
   logic [LEN_W-1:0]         index_ff, index_in;
   logic                     running_ff, running_in;

   // sample being worked on
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [LEVEL_W-1:0]       duty_ff, duty_in;
   logic                     last_ff, last_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]        rsp_addr_ff;
   logic [LEVEL_W-1:0]       rsp_duty_ff;
   logic                     rsp_last_ff;
   logic                     out_load;

   // evaluation of the current index
   logic                     req_take;
   logic [ADDR_SUM_W-1:0]    addr_sum;
   logic                     out_of_range;
   logic                     is_last;
   logic [LEN_W-1:0]         remaining;
   logic                     in_fade_in;
   logic                     in_fade_out;
   logic [LEN_W-1:0]         fade_pos;
   logic [LEN_W-1:0]         fade_len;
   logic                     need_div;

   phase_ctrl_type           phase_ctrl;
   logic                     phase_high;
   div_req_type              div_req;
   logic                     div_busy;
   logic [LEVEL_W-1:0]       div_quotient;

   // ---------------- register file ----------------
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_address_ff   <= '0;
         burst_length_ff    <= '0;
         phase_step_ff      <= '0;
         step_change_ff     <= '0;
         fade_in_length_ff  <= '0;
         fade_out_length_ff <= '0;
         peak_level_ff      <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_START_ADDRESS:   start_address_ff   <= csr_data[ADDR_W-1:0];
            CSR_BURST_LENGTH:    burst_length_ff    <= csr_data[LEN_W-1:0];
            CSR_PHASE_STEP:      phase_step_ff      <= csr_data[STEP_W-1:0];
            CSR_STEP_CHANGE:     step_change_ff     <= signed'(csr_data[STEP_W-1:0]);
            CSR_FADE_IN_LENGTH:  fade_in_length_ff  <= csr_data[LEN_W-1:0];
            CSR_FADE_OUT_LENGTH: fade_out_length_ff <= csr_data[LEN_W-1:0];
            CSR_PEAK_LEVEL:      peak_level_ff      <= csr_data[LEVEL_W-1:0];
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // ---------------- sample evaluation ----------------
   always_comb begin
      addr_sum     = ADDR_SUM_W'(start_address_ff) + ADDR_SUM_W'(index_ff);
      out_of_range = (index_ff >= burst_length_ff) ||
                     (addr_sum >= ADDR_SUM_W'(MEMORY_DEPTH));
      // final sample of the burst, or the last word of the memory
      is_last      = (({1'b0, index_ff} + 1'b1) == {1'b0, burst_length_ff}) ||
                     ((addr_sum + 1'b1) == ADDR_SUM_W'(MEMORY_DEPTH));
      remaining    = burst_length_ff - index_ff;
      in_fade_in   = index_ff < fade_in_length_ff;
      in_fade_out  = remaining < fade_out_length_ff;
      fade_pos     = in_fade_in ? index_ff : remaining;
      fade_len     = in_fade_in ? fade_in_length_ff : fade_out_length_ff;
      need_div     = ~phase_high & (in_fade_in | in_fade_out);
   end

   // ---------------- sequencer ----------------
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign out_load  = (state_ff == ST_FINISH) & (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      state_in           = state_ff;
      index_in           = index_ff;
      running_in         = running_ff;
      addr_in            = addr_ff;
      duty_in            = duty_ff;
      last_in            = last_ff;
      phase_ctrl.load    = 1'b0;
      phase_ctrl.advance = 1'b0;
      div_req.start      = 1'b0;
      // one product per fade sample, registered in the divider
      div_req.numerator  = PROD_W'(fade_pos) * PROD_W'(peak_level_ff);
      div_req.divisor    = fade_len;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_restart) begin
                  index_in        = '0;
                  running_in      = 1'b1;
                  phase_ctrl.load = 1'b1;
                  state_in        = ST_EVAL;
               end else if (running_ff) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (out_of_range) begin
               // empty burst or start past the memory end: no sample
               running_in = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               addr_in = addr_sum[ADDR_W-1:0];
               last_in = is_last;
               duty_in = phase_high ? '0 : peak_level_ff;
               if (is_last) begin
                  running_in = 1'b0;
               end else begin
                  index_in           = index_ff + 1'b1;
                  phase_ctrl.advance = 1'b1;
               end
               if (need_div) begin
                  div_req.start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               duty_in  = div_quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         index_ff   <= '0;
         running_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         index_ff   <= index_in;
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      duty_ff <= duty_in;
      last_ff <= last_in;
   end

   // ---------------- output register ----------------
   // holds a finished sample until it is taken, so the next tick can start
   assign rsp_valid_in = out_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_addr_ff <= addr_ff;
         rsp_duty_ff <= duty_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sample_address = rsp_addr_ff;
   assign rsp_duty           = rsp_duty_ff;
   assign rsp_last           = rsp_last_ff;

   // ---------------- datapath units ----------------
   tbpg_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .phase_ctrl  (phase_ctrl),
      .phase_step  (phase_step_ff),
      .step_change (step_change_ff),
      .phase_high  (phase_high)
   );

   tbpg_serial_div u_div (
      .clock        (clock),
      .reset        (reset),
      .div_req      (div_req),
      .div_busy     (div_busy),
      .div_quotient (div_quotient)
   );

endmodule

`default_nettype wire

@@ rtl/tbpg_checker.sv @@
// port-level checks of the tone burst pwm generator, bound to the top level
// depends on tbpg_pkg and tone_burst_pwm_generator_unit_assert.svh
`default_nettype none

`include "tone_burst_pwm_generator_unit_assert.svh"

module tbpg_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           req_restart,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic [tbpg_pkg::ADDR_W-1:0]    rsp_sample_address,
   input logic [tbpg_pkg::LEVEL_W-1:0]   rsp_duty,
   input logic                           rsp_last
);

   // a sample waiting at the output stays offered
   `TBPG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // and its payload does not move
   `TBPG_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
      $stable(rsp_sample_address) && $stable(rsp_duty) && $stable(rsp_last))

   // a restart transfer always starts work, so the tick channel is held off
   `TBPG_ASSERT_NEXT(a_restart_busy, clock, reset,
      req_valid && !req_stall && req_restart, req_stall)

   // nothing is offered straight out of reset
   `TBPG_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind tone_burst_pwm_generator_unit tbpg_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .req_restart        (req_restart),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_sample_address (rsp_sample_address),
   .rsp_duty           (rsp_duty),
   .rsp_last           (rsp_last)
);

`default_nettype wire

@@ tb/sv/tb_tone_burst_pwm_generator_unit.sv @@
// self-checking testbench of the tone burst pwm generator: directed rows, then random bursts
// depends on tbpg_pkg and tone_burst_pwm_generator_unit; samples checked against a local model
`timescale 1ns / 1ps

module tb_tone_burst_pwm_generator_unit;
   import tbpg_pkg::*;

   localparam int RANDOM_TICKS  = 1100;
   localparam int SETTLE_CYCLES = 40;    // longer than the longest tick
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int QUIET_LIMIT   = 5000;  // cycles without any transfer

   // one duty sample as seen on the rsp_ channel
   typedef struct packed {
      logic [ADDR_W-1:0]  sample_address;
      logic [LEVEL_W-1:0] duty;
      logic               last;
   } tone_sample_type;

   typedef enum {ROW_REG, ROW_TICK} row_kind_type;

   typedef enum {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_mode_type;

   // one row of the directed stimulus; typed rows carry their own expected outcome
   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_data;
      bit                     restart;
      bit                     typed;
      bit                     typed_has;
      tone_sample_type        typed_sample;
   } stim_row_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic                   req_restart = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic [ADDR_W-1:0]      rsp_sample_address;
   logic [LEVEL_W-1:0]     rsp_duty;
   logic                   rsp_last;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   tone_burst_pwm_generator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_address (rsp_sample_address),
      .rsp_duty           (rsp_duty),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // local model of the generator: register copies and burst state
   // ---------------------------------------------------------------------------------------
   logic [ADDR_W-1:0]         cfg_start    = '0;
   logic [LEN_W-1:0]          cfg_length   = '0;
   logic [STEP_W-1:0]         cfg_step     = '0;
   logic signed [STEP_W-1:0]  cfg_chirp    = '0;
   logic [LEN_W-1:0]          cfg_fade_in  = '0;
   logic [LEN_W-1:0]          cfg_fade_out = '0;
   logic [LEVEL_W-1:0]        cfg_peak     = '0;

   logic [LEN_W-1:0]          tone_index   = '0;
   logic [PHASE_BITS-1:0]     tone_phase   = '0;
   logic [STEP_W-1:0]         tone_step    = '0;
   bit                        tone_running = 1'b0;

   tone_sample_type expected_samples[$];
   stim_row_type    directed_rows[$];

   int  error_count      = 0;
   int  ticks_sent       = 0;   // ticks that restart or give a sample
   int  send_idle_pct    = 0;
   int  stall_pct        = 0;
   bit  pressure_pending = 1'b0;

   // register copy, masked to the widths of the block
   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_START_ADDRESS:   cfg_start    = value[ADDR_W-1:0];
         CSR_BURST_LENGTH:    cfg_length   = value[LEN_W-1:0];
         CSR_PHASE_STEP:      cfg_step     = value[STEP_W-1:0];
         CSR_STEP_CHANGE:     cfg_chirp    = value[STEP_W-1:0];
         CSR_FADE_IN_LENGTH:  cfg_fade_in  = value[LEN_W-1:0];
         CSR_FADE_OUT_LENGTH: cfg_fade_out = value[LEN_W-1:0];
         CSR_PEAK_LEVEL:      cfg_peak     = value[LEVEL_W-1:0];
         default: ;
      endcase
   endfunction

   // one tick of the burst; returns 1 when the tick gives a sample
   function automatic bit next_duty_sample(input bit restart, output tone_sample_type s);
      longint idx, addr, dend, level, acc, stepped, aligned;
      longint half, full;
      half = longint'(1) << (PHASE_BITS - 1);
      full = longint'(1) << PHASE_BITS;
      s = '0;
      if (restart) begin
         tone_index   = '0;
         tone_phase   = '0;
         tone_step    = cfg_step;
         tone_running = 1'b1;
      end
      if (!tone_running)
         return 1'b0;

      idx  = longint'(tone_index);
      addr = longint'(cfg_start) + idx;
      // past the burst or past the memory: stop without a sample
      if (idx >= longint'(cfg_length) || addr >= longint'(MEMORY_DEPTH)) begin
         tone_running = 1'b0;
         return 1'b0;
      end

      if (longint'(tone_phase) >= half) begin
         level = 0;
      end else begin
         dend = longint'(cfg_length) - idx;
         if (idx < longint'(cfg_fade_in))
            level = (idx * longint'(cfg_peak)) / longint'(cfg_fade_in);
         else if (dend < longint'(cfg_fade_out))
            level = (dend * longint'(cfg_peak)) / longint'(cfg_fade_out);
         else
            level = longint'(cfg_peak);
      end

      s.sample_address = addr[ADDR_W-1:0];
      s.duty           = level[LEVEL_W-1:0];
      s.last           = (idx + 1 == longint'(cfg_length)) ||
                         (addr + 1 == longint'(MEMORY_DEPTH));

      if (s.last) begin
         tone_running = 1'b0;
      end else begin
         if (PHASE_BITS >= STEP_W)
            aligned = longint'(tone_step) << (PHASE_BITS - STEP_W);
         else
            aligned = longint'(tone_step) >> (STEP_W - PHASE_BITS);
         acc        = longint'(tone_phase) + aligned;
         tone_index = tone_index + 1'b1;
         // wrap: chirp the step, saturating to the unsigned step range
         if (acc >= full) begin
            stepped = longint'(tone_step) + longint'(cfg_chirp);
            if (stepped < 0)
               stepped = 0;
            if (stepped > (longint'(1) << STEP_W) - 1)
               stepped = (longint'(1) << STEP_W) - 1;
            tone_step = stepped[STEP_W-1:0];
            acc       = acc - full;
         end
         tone_phase = acc[PHASE_BITS-1:0];
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------------------------
   // directed stimulus rows
   // ---------------------------------------------------------------------------------------
   function automatic stim_row_type blank_row(input row_kind_type kind);
      stim_row_type r;
      r.kind         = kind;
      r.reg_index    = '0;
      r.reg_data     = '0;
      r.restart      = 1'b0;
      r.typed        = 1'b0;
      r.typed_has    = 1'b0;
      r.typed_sample = '0;
      return r;
   endfunction

   function automatic void add_reg(input logic [CSR_INDEX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
      stim_row_type r;
      r           = blank_row(ROW_REG);
      r.reg_index = idx;
      r.reg_data  = value;
      directed_rows.push_back(r);
   endfunction

   // tick whose sample comes from the local model
   function automatic void add_tick(input bit restart);
      stim_row_type r;
      r         = blank_row(ROW_TICK);
      r.restart = restart;
      directed_rows.push_back(r);
   endfunction

   // tick known to give no sample
   function automatic void add_tick_none(input bit restart);
      stim_row_type r;
      r         = blank_row(ROW_TICK);
      r.restart = restart;
      r.typed   = 1'b1;
      directed_rows.push_back(r);
   endfunction

   // tick with its sample typed in
   function automatic void add_tick_sample(input bit restart, input int addr,
                                           input int duty, input bit last);
      stim_row_type r;
      r                             = blank_row(ROW_TICK);
      r.restart                     = restart;
      r.typed                       = 1'b1;
      r.typed_has                   = 1'b1;
      r.typed_sample.sample_address = addr[ADDR_W-1:0];
      r.typed_sample.duty           = duty[LEVEL_W-1:0];
      r.typed_sample.last           = last;
      directed_rows.push_back(r);
   endfunction

   function automatic void build_directed_rows();
      // idle after reset, then an empty burst with all registers at zero
      add_tick_none(1'b0);
      add_tick_none(1'b1);
      // single-sample burst at full level, nothing after its last sample
      add_reg(CSR_PEAK_LEVEL, 20'd32767);
      add_reg(CSR_BURST_LENGTH, 20'd1);
      add_tick_sample(1'b1, 0, 32767, 1'b1);
      add_tick_none(1'b0);
      // top address of the memory ends a long burst at once
      add_reg(CSR_START_ADDRESS, 20'd16383);
      add_reg(CSR_BURST_LENGTH, 20'd16384);
      add_tick_sample(1'b1, 16383, 32767, 1'b1);
      add_tick_none(1'b0);
      // quarter-cycle step, largest upward chirp, short fades, restart mid-burst
      add_reg(CSR_START_ADDRESS, 20'd100);
      add_reg(CSR_BURST_LENGTH, 20'd10);
      add_reg(CSR_PHASE_STEP, 20'h40000);
      add_reg(CSR_STEP_CHANGE, 20'h7FFFF);
      add_reg(CSR_FADE_IN_LENGTH, 20'd3);
      add_reg(CSR_FADE_OUT_LENGTH, 20'd3);
      add_reg(CSR_PEAK_LEVEL, 20'd1000);
      add_tick_sample(1'b1, 100, 0, 1'b0);
      repeat (3) add_tick(1'b0);
      add_tick(1'b1);
      repeat (9) add_tick(1'b0);
      add_tick_none(1'b0);
      // largest step, most negative chirp, long fade-in, burst cut by the memory end
      add_reg(CSR_START_ADDRESS, 20'd16380);
      add_reg(CSR_BURST_LENGTH, 20'd20);
      add_reg(CSR_PHASE_STEP, 20'hFFFFF);
      add_reg(CSR_STEP_CHANGE, 20'h80000);
      add_reg(CSR_FADE_IN_LENGTH, 20'd16384);
      add_reg(CSR_FADE_OUT_LENGTH, 20'd0);
      add_reg(CSR_PEAK_LEVEL, 20'd32767);
      add_tick(1'b1);
      repeat (3) add_tick(1'b0);
   endfunction

   // random register values, biased towards small bursts and the range ends
   function automatic logic [CSR_DATA_W-1:0] random_reg_value(
         input logic [CSR_INDEX_W-1:0] idx);
      int pick;
      int v;
      pick = $urandom_range(0, 9);
      v    = 0;
      case (idx)
         CSR_START_ADDRESS:
            if (pick < 6)       v = $urandom_range(0, 200);
            else if (pick < 8)  v = $urandom_range(16300, 16383);
            else if (pick == 8) v = 0;
            else                v = $urandom_range(0, 16383);
         CSR_BURST_LENGTH:
            if (pick < 7)       v = $urandom_range(1, 48);
            else if (pick == 7) v = 0;
            else if (pick == 8) v = 16384;
            else                v = $urandom_range(0, 16384);
         CSR_PHASE_STEP:
            if (pick < 4)       v = $urandom_range(0, 20'hFFFFF);
            else if (pick < 7)  v = $urandom_range(20'h10000, 20'h80000);
            else if (pick == 7) v = 0;
            else if (pick == 8) v = 20'hFFFFF;
            else                v = $urandom_range(1, 4096);
         CSR_STEP_CHANGE:
            if (pick < 5)       v = int'($urandom_range(0, 131071)) - 65536;
            else if (pick == 5) v = -524288;
            else if (pick == 6) v = 524287;
            else if (pick == 7) v = 0;
            else                v = $urandom_range(0, 20'hFFFFF);
         CSR_FADE_IN_LENGTH, CSR_FADE_OUT_LENGTH:
            if (pick < 3)       v = 0;
            else if (pick < 7)  v = $urandom_range(1, 24);
            else if (pick == 7) v = 16384;
            else if (pick == 8) v = $urandom_range(1, 16384);
            else                v = 1;
         CSR_PEAK_LEVEL:
            if (pick < 6)       v = $urandom_range(0, 32767);
            else if (pick == 6) v = 32767;
            else if (pick == 7) v = 0;
            else if (pick == 8) v = 1;
            else                v = $urandom_range(0, 64);
         default: v = 0;
      endcase
      return v[CSR_DATA_W-1:0];
   endfunction

   // ---------------------------------------------------------------------------------------
   // channel drivers, all at the rising edge
   // ---------------------------------------------------------------------------------------
   task automatic set_flow(input flow_mode_type mode);
      case (mode)
         FLOW_FREE:           begin send_idle_pct = 0;  stall_pct = 0;  end
         FLOW_SENDER_IDLE:    begin send_idle_pct = 80; stall_pct = 0;  end
         FLOW_RECEIVER_STALL: begin send_idle_pct = 0;  stall_pct = 80; end
         default:             begin send_idle_pct = 25; stall_pct = 25; end
      endcase
   endtask

   // register write; valid stays up for a following write, the next tick lowers it
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      apply_reg(idx, value);
   endtask

   task automatic write_random_regs(input bit all);
      logic [CSR_INDEX_W-1:0] idx;
      for (int n = 0; n <= int'(CSR_PEAK_LEVEL); n++) begin
         idx = n[CSR_INDEX_W-1:0];
         if (all || $urandom_range(0, 99) < 70)
            write_reg(idx, random_reg_value(idx));
      end
   endtask

   // one tick transfer; the expected sample is worked out at its acceptance
   task automatic send_tick(input bit restart, input bit typed, input bit typed_has,
                            input tone_sample_type typed_sample);
      tone_sample_type s;
      bit              has;
      csr_valid <= 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      has = next_duty_sample(restart, s);
      if (has || restart)
         ticks_sent++;
      // typed rows overrule the model, which still keeps its state in step
      if (typed) begin
         has = typed_has;
         s   = typed_sample;
      end
      if (has)
         expected_samples.push_back(s);
   endtask

   // let the block fall idle before a register write
   task automatic settle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: random stall, plus one long hold-off when asked
   initial begin : sample_receiver
      forever begin
         @(posedge clock);
         if (pressure_pending) begin
            pressure_pending = 1'b0;
            rsp_stall <= 1'b1;
            for (int k = 0; k < HOLD_CYCLES; k++)
               @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // sample checker: every transfer against the oldest expected sample
   always @(posedge clock) begin : sample_checker
      tone_sample_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_samples.size() == 0) begin
            $error("unexpected sample transfer: sample_address %0d duty %0d last %0b",
                   rsp_sample_address, rsp_duty, rsp_last);
            error_count++;
         end else begin
            want = expected_samples.pop_front();
            if (rsp_sample_address !== want.sample_address) begin
               $error("sample_address: expected %0d, got %0d",
                      want.sample_address, rsp_sample_address);
               error_count++;
            end
            if (rsp_duty !== want.duty) begin
               $error("duty: expected %0d, got %0d", want.duty, rsp_duty);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   // watchdog: too long without any transfer on any channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tone_burst_pwm_generator_unit regression: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      bit            after_ticks;
      bit            restart;
      bit            pressure_phase;
      int            directed_ticks;
      int            phase_no;
      int            burst_ticks;
      flow_mode_type flow;

      after_ticks = 1'b0;
      phase_no    = 0;
      build_directed_rows();
      set_flow(FLOW_FREE);

      // reset held at the start, once
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows; register writes wait for the block to go idle
      foreach (directed_rows[n]) begin
         if (directed_rows[n].kind == ROW_REG) begin
            if (after_ticks) begin
               settle();
               after_ticks = 1'b0;
            end
            write_reg(directed_rows[n].reg_index, directed_rows[n].reg_data);
         end else begin
            send_tick(directed_rows[n].restart, directed_rows[n].typed,
                      directed_rows[n].typed_has, directed_rows[n].typed_sample);
            after_ticks = 1'b1;
         end
      end
      directed_ticks = ticks_sent;

      // random phases: new registers, then bursts with random restarts
      while (ticks_sent - directed_ticks < RANDOM_TICKS) begin
         settle();
         flow = (phase_no < 4) ? flow_mode_type'(phase_no) :
                                 flow_mode_type'($urandom_range(0, 3));
         set_flow(flow);
         write_random_regs(phase_no == 0);
         burst_ticks    = $urandom_range(20, 60);
         pressure_phase = (phase_no == 4 || phase_no == 17);
         // long burst while the receiver holds off, so the block backs up
         if (pressure_phase) begin
            set_flow(FLOW_FREE);
            write_reg(CSR_START_ADDRESS, '0);
            write_reg(CSR_BURST_LENGTH, 20'd16384);
            pressure_pending = 1'b1;
            burst_ticks      = 60;
         end
         for (int k = 0; k < burst_ticks; k++) begin
            // restart mostly once a burst has ended, seldom in the middle
            if (pressure_phase && k == 0)
               restart = 1'b1;
            else if (!tone_running)
               restart = ($urandom_range(0, 9) < 6);
            else
               restart = ($urandom_range(0, 99) < 3);
            send_tick(restart, 1'b0, 1'b0, '0);
         end
         phase_no++;
      end

      // drain and final verdict
      req_valid <= 1'b0;
      while (expected_samples.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tone_burst_pwm_generator_unit regression: pass");
      else
         $display("tone_burst_pwm_generator_unit regression: fail");
      $finish;
   end

endmodule
